// ----- rtl/jdr_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// jdr_pkg
// Shared types and constants for the joystick deadzone rescale core.
// ============================================================================
package jdr_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = SAMPLE_BITS - 1;
   localparam int GUARD_BITS  = 32 - SAMPLE_BITS;
   localparam int SQ_BITS     = 2 * SAMPLE_BITS;
   localparam int ROOT_BITS   = (SQ_BITS + 2 * GUARD_BITS) / 2;
   localparam int REM_BITS    = ROOT_BITS + 2;
   localparam int DIV_BITS    = SAMPLE_BITS + ROOT_BITS;
   localparam int SQRT_CELLS  = ROOT_BITS;
   localparam int DIV_CELLS   = FRAC_BITS;
   // Input register, squares, radius sum, root cells, product stage,
   // saturation stage, divider cells and the output register.
   localparam int LATENCY     = 3 + SQRT_CELLS + 2 + DIV_CELLS + 1;

   localparam logic CSR_ZONE_MODE = 1'b0;
   localparam logic CSR_ZONE_SIZE = 1'b1;

   localparam logic MODE_AXIAL  = 1'b0;
   localparam logic MODE_RADIAL = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x_in;
      logic signed [SAMPLE_BITS-1:0] y_in;
   } jdr_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x_out;
      logic signed [SAMPLE_BITS-1:0] y_out;
   } jdr_rsp_type;

   typedef struct packed {
      logic                 mode;
      logic [FRAC_BITS-1:0] zsize;
      logic [SAMPLE_BITS-1:0] xm;
      logic [SAMPLE_BITS-1:0] ym;
      logic                 xn;
      logic                 yn;
      logic                 zero;
   } jdr_side_type;

   typedef struct packed {
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
      logic [SQ_BITS-1:0]   pend;
   } jdr_sqrt_type;

   typedef struct packed {
      logic [DIV_BITS-1:0]  rem_x;
      logic [DIV_BITS-1:0]  rem_y;
      logic [DIV_BITS-1:0]  d;
      logic [FRAC_BITS-1:0] q_x;
      logic [FRAC_BITS-1:0] q_y;
      logic                 sat_x;
      logic                 sat_y;
      logic                 zero_x;
      logic                 zero_y;
      logic                 xn;
      logic                 yn;
   } jdr_div_type;

endpackage

// ----- rtl/joystick_deadzone_rescale_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// joystick_deadzone_rescale_core
// Axial or radial stick deadzone with rescaling to the full range.
// ============================================================================
// The core takes one stick sample in every clock cycle (busy is always low)
// and delivers each result at the end of its pipeline as a one-cycle
// beat on rsp_valid; the receiver cannot stall the core and must take every
// result beat. The latency is set by the 32 square root cells (two radicand
// bits each) and the 15 divider cells (one quotient bit each), plus six
// stages for input capture, squaring, the radius sum, the scaling products,
// the saturation check and the output register. Mode and threshold should
// only be written while no sample is in flight.
module joystick_deadzone_rescale_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  jdr_pkg::jdr_req_type                req_data,
   output logic                                rsp_valid,
   output jdr_pkg::jdr_rsp_type                rsp_data,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [jdr_pkg::FRAC_BITS-1:0]       csr_wdata
);

   localparam int SB = jdr_pkg::SAMPLE_BITS;
   localparam int FB = jdr_pkg::FRAC_BITS;
   localparam int DB = jdr_pkg::DIV_BITS;
   localparam int RB = jdr_pkg::ROOT_BITS;

   // Configuration registers.
   logic          zone_mode_ff;
   logic [FB-1:0] zone_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_mode_ff <= jdr_pkg::MODE_AXIAL;
         zone_size_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            jdr_pkg::CSR_ZONE_MODE: zone_mode_ff <= csr_wdata[0];
            jdr_pkg::CSR_ZONE_SIZE: zone_size_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Input capture: sign and magnitude of each axis, with the settings.
   logic                  s0_valid_ff;
   jdr_pkg::jdr_side_type s0_side_ff;
   jdr_pkg::jdr_side_type s0_side_in;

   always_comb begin
      s0_side_in.mode  = zone_mode_ff;
      s0_side_in.zsize = zone_size_ff;
      s0_side_in.xn    = req_data.x_in[SB-1];
      s0_side_in.yn    = req_data.y_in[SB-1];
      // A full negative input maps to the magnitude one, which still fits.
      s0_side_in.xm    = s0_side_in.xn ? SB'(~req_data.x_in + 1'b1) : req_data.x_in;
      s0_side_in.ym    = s0_side_in.yn ? SB'(~req_data.y_in + 1'b1) : req_data.y_in;
      s0_side_in.zero  = 1'b0;
   end

   // Squares of both magnitudes and of the threshold.
   logic                  s1_valid_ff;
   jdr_pkg::jdr_side_type s1_side_ff;
   logic [2*SB-1:0]       s1_xsq_ff;
   logic [2*SB-1:0]       s1_ysq_ff;
   logic [2*FB-1:0]       s1_asq_ff;

   // Radius squared and the inside-the-circle test.
   logic                  s2_valid_ff;
   jdr_pkg::jdr_side_type s2_side_ff;
   logic [2*SB-1:0]       s2_r2_ff;
   logic [2*SB-1:0]       s2_r2_in;
   jdr_pkg::jdr_side_type s2_side_in;

   assign s2_r2_in = s1_xsq_ff + s1_ysq_ff;

   always_comb begin
      s2_side_in      = s1_side_ff;
      s2_side_in.zero = (s2_r2_in < (2*SB)'(s1_asq_ff)) || (s2_r2_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
      s0_side_ff <= s0_side_in;
      s1_side_ff <= s0_side_ff;
      s1_xsq_ff  <= s0_side_ff.xm * s0_side_ff.xm;
      s1_ysq_ff  <= s0_side_ff.ym * s0_side_ff.ym;
      s1_asq_ff  <= s0_side_ff.zsize * s0_side_ff.zsize;
      s2_side_ff <= s2_side_in;
      s2_r2_ff   <= s2_r2_in;
   end

   // Square root chain: the radicand is r2 followed by 2*GUARD_BITS zeros.
   logic                  sq_valid [0:jdr_pkg::SQRT_CELLS];
   jdr_pkg::jdr_side_type sq_side  [0:jdr_pkg::SQRT_CELLS];
   jdr_pkg::jdr_sqrt_type sq_data  [0:jdr_pkg::SQRT_CELLS];

   assign sq_valid[0]     = s2_valid_ff;
   assign sq_side[0]      = s2_side_ff;
   assign sq_data[0].rem  = '0;
   assign sq_data[0].root = '0;
   assign sq_data[0].pend = s2_r2_ff;

   for (genvar gi = 0; gi < jdr_pkg::SQRT_CELLS; gi++) begin : g_sqrt
      jdr_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[gi]),
         .in_side   (sq_side[gi]),
         .in_data   (sq_data[gi]),
         .out_valid (sq_valid[gi+1]),
         .out_side  (sq_side[gi+1]),
         .out_data  (sq_data[gi+1])
      );
   end

   // Scaling products. Radial: p = |c| * (R - A), d = (one - a) * R.
   // Axial: p = |v| - a, d = one - a.
   jdr_pkg::jdr_side_type sd;
   logic [RB-1:0]         root;
   logic [RB-1:0]         span;
   logic [SB-1:0]         one_minus_a;

   logic          p_valid_ff;
   logic [DB-1:0] p_x_ff;
   logic [DB-1:0] p_y_ff;
   logic [DB-1:0] p_d_ff;
   logic          p_zx_ff;
   logic          p_zy_ff;
   logic          p_xn_ff;
   logic          p_yn_ff;
   logic [DB-1:0] p_x_in;
   logic [DB-1:0] p_y_in;
   logic [DB-1:0] p_d_in;
   logic          p_zx_in;
   logic          p_zy_in;

   always_comb begin
      sd          = sq_side[jdr_pkg::SQRT_CELLS];
      root        = sq_data[jdr_pkg::SQRT_CELLS].root;
      span        = root - RB'({sd.zsize, {jdr_pkg::GUARD_BITS{1'b0}}});
      one_minus_a = {1'b1, {FB{1'b0}}} - {1'b0, sd.zsize};
      if (sd.mode == jdr_pkg::MODE_RADIAL) begin
         p_x_in  = sd.xm * span;
         p_y_in  = sd.ym * span;
         p_d_in  = one_minus_a * root;
         p_zx_in = sd.zero;
         p_zy_in = sd.zero;
      end else begin
         p_x_in  = DB'(sd.xm - {1'b0, sd.zsize});
         p_y_in  = DB'(sd.ym - {1'b0, sd.zsize});
         p_d_in  = DB'(one_minus_a);
         p_zx_in = sd.xm < {1'b0, sd.zsize};
         p_zy_in = sd.ym < {1'b0, sd.zsize};
      end
   end

   // Saturation check: the quotient reaches one exactly when p >= d.
   logic                 dv_valid [0:jdr_pkg::DIV_CELLS];
   jdr_pkg::jdr_div_type dv_data  [0:jdr_pkg::DIV_CELLS];
   logic                 q_valid_ff;
   jdr_pkg::jdr_div_type q_data_ff;
   jdr_pkg::jdr_div_type q_data_in;

   always_comb begin
      q_data_in.rem_x  = p_x_ff;
      q_data_in.rem_y  = p_y_ff;
      q_data_in.d      = p_d_ff;
      q_data_in.q_x    = '0;
      q_data_in.q_y    = '0;
      q_data_in.sat_x  = p_x_ff >= p_d_ff;
      q_data_in.sat_y  = p_y_ff >= p_d_ff;
      q_data_in.zero_x = p_zx_ff;
      q_data_in.zero_y = p_zy_ff;
      q_data_in.xn     = p_xn_ff;
      q_data_in.yn     = p_yn_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= sq_valid[jdr_pkg::SQRT_CELLS];
         q_valid_ff <= p_valid_ff;
      end
      p_x_ff    <= p_x_in;
      p_y_ff    <= p_y_in;
      p_d_ff    <= p_d_in;
      p_zx_ff   <= p_zx_in;
      p_zy_ff   <= p_zy_in;
      p_xn_ff   <= sd.xn;
      p_yn_ff   <= sd.yn;
      q_data_ff <= q_data_in;
   end

   assign dv_valid[0] = q_valid_ff;
   assign dv_data[0]  = q_data_ff;

   for (genvar gi = 0; gi < jdr_pkg::DIV_CELLS; gi++) begin : g_div
      jdr_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[gi]),
         .in_data   (dv_data[gi]),
         .out_valid (dv_valid[gi+1]),
         .out_data  (dv_data[gi+1])
      );
   end

   // Output: saturate, clear dead-zoned axes and restore the sign.
   jdr_pkg::jdr_div_type fin;
   logic [SB-1:0]        mag_x;
   logic [SB-1:0]        mag_y;
   jdr_pkg::jdr_rsp_type rsp_data_in;
   logic                 rsp_valid_ff;
   jdr_pkg::jdr_rsp_type rsp_data_ff;

   always_comb begin
      fin   = dv_data[jdr_pkg::DIV_CELLS];
      mag_x = fin.sat_x ? {1'b0, {FB{1'b1}}} : {1'b0, fin.q_x};
      mag_y = fin.sat_y ? {1'b0, {FB{1'b1}}} : {1'b0, fin.q_y};
      if (fin.zero_x) begin
         mag_x = '0;
      end
      if (fin.zero_y) begin
         mag_y = '0;
      end
      rsp_data_in.x_out = fin.xn ? SB'(~mag_x + 1'b1) : mag_x;
      rsp_data_in.y_out = fin.yn ? SB'(~mag_y + 1'b1) : mag_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid[jdr_pkg::DIV_CELLS];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/jdr_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ============================================================================
// jdr_sqrt_cell
// One digit of the restoring square root; takes two radicand bits per beat.
// ============================================================================
module jdr_sqrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  jdr_pkg::jdr_side_type in_side,
   input  jdr_pkg::jdr_sqrt_type in_data,
   output logic                  out_valid,
   output jdr_pkg::jdr_side_type out_side,
   output jdr_pkg::jdr_sqrt_type out_data
);

   logic                  valid_ff;
   jdr_pkg::jdr_side_type side_ff;
   jdr_pkg::jdr_sqrt_type data_ff;
   jdr_pkg::jdr_sqrt_type data_in;
   logic [jdr_pkg::REM_BITS+1:0] rem_sh;
   logic [jdr_pkg::REM_BITS+1:0] trial;

   always_comb begin
      rem_sh = {in_data.rem, in_data.pend[jdr_pkg::SQ_BITS-1 -: 2]};
      trial  = {2'b00, in_data.root, 2'b01};
      data_in.pend = {in_data.pend[jdr_pkg::SQ_BITS-3:0], 2'b00};
      if (rem_sh >= trial) begin
         data_in.rem  = jdr_pkg::REM_BITS'(rem_sh - trial);
         data_in.root = {in_data.root[jdr_pkg::ROOT_BITS-2:0], 1'b1};
      end else begin
         data_in.rem  = rem_sh[jdr_pkg::REM_BITS-1:0];
         data_in.root = {in_data.root[jdr_pkg::ROOT_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      side_ff <= in_side;
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/jdr_div_cell.sv -----
`timescale 1ns / 1ps
// ============================================================================
// jdr_div_cell
// One quotient bit of the restoring divider for both axes.
// ============================================================================
module jdr_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  jdr_pkg::jdr_div_type in_data,
   output logic                 out_valid,
   output jdr_pkg::jdr_div_type out_data
);

   logic                 valid_ff;
   jdr_pkg::jdr_div_type data_ff;
   jdr_pkg::jdr_div_type data_in;
   logic [jdr_pkg::DIV_BITS:0] rx2;
   logic [jdr_pkg::DIV_BITS:0] ry2;
   logic [jdr_pkg::DIV_BITS:0] dd;

   always_comb begin
      data_in = in_data;
      rx2 = {in_data.rem_x, 1'b0};
      ry2 = {in_data.rem_y, 1'b0};
      dd  = {1'b0, in_data.d};
      if (rx2 >= dd) begin
         data_in.rem_x = jdr_pkg::DIV_BITS'(rx2 - dd);
         data_in.q_x   = {in_data.q_x[jdr_pkg::FRAC_BITS-2:0], 1'b1};
      end else begin
         data_in.rem_x = rx2[jdr_pkg::DIV_BITS-1:0];
         data_in.q_x   = {in_data.q_x[jdr_pkg::FRAC_BITS-2:0], 1'b0};
      end
      if (ry2 >= dd) begin
         data_in.rem_y = jdr_pkg::DIV_BITS'(ry2 - dd);
         data_in.q_y   = {in_data.q_y[jdr_pkg::FRAC_BITS-2:0], 1'b1};
      end else begin
         data_in.rem_y = ry2[jdr_pkg::DIV_BITS-1:0];
         data_in.q_y   = {in_data.q_y[jdr_pkg::FRAC_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/jdr_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// jdr_checker
// Port-level checks of latency and output range for the deadzone core.
// ============================================================================
module jdr_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input jdr_pkg::jdr_rsp_type rsp_data
);

   // Every accepted beat yields a result beat after the fixed latency.
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(jdr_pkg::LATENCY) rsp_valid)
      else $error("result beat missing after fixed latency");

   // No result beat without an accepted beat the fixed latency earlier.
   a_latency_bwd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, jdr_pkg::LATENCY))
      else $error("result beat without matching request");

   // Saturation keeps both outputs off the most negative code.
   a_x_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.x_out != {1'b1, {jdr_pkg::FRAC_BITS{1'b0}}})
      else $error("x_out outside saturated range");

   a_y_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.y_out != {1'b1, {jdr_pkg::FRAC_BITS{1'b0}}})
      else $error("y_out outside saturated range");

endmodule

bind joystick_deadzone_rescale_core jdr_checker u_jdr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
